>>> rtl/tcu_pkg.sv
// Shared types and constants of the tricritical contact update engine.
`default_nettype none

package tcu_pkg;

  localparam int SIDE     = 1024;
  localparam int COORD_W  = 10;
  localparam int ADDR_W   = 2 * COORD_W;
  localparam int CELLS    = SIDE * SIDE;
  localparam int CNT_W    = 21;
  localparam int FRAC_W   = 16;
  localparam int ACTION_W = 2;
  localparam int DIR_W    = 2;
  localparam int CHOICE_W = 3;
  localparam int CFG_IDX_W = 1;

  typedef logic [COORD_W-1:0]  coord_t;
  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [CNT_W-1:0]    count_t;
  typedef logic [FRAC_W-1:0]   frac_t;
  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [DIR_W-1:0]    dir_t;
  typedef logic [CHOICE_W-1:0] choice_t;

  localparam action_t ACT_UPDATE = 2'd0;
  localparam action_t ACT_WRITE  = 2'd1;
  localparam action_t ACT_READ   = 2'd2;

  localparam dir_t DIR_UP    = 2'd0;
  localparam dir_t DIR_DOWN  = 2'd1;
  localparam dir_t DIR_LEFT  = 2'd2;
  localparam dir_t DIR_RIGHT = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_BIRTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAIR  = 1'b1;

  localparam frac_t BIRTH_RESET = 16'd21072;
  localparam frac_t PAIR_RESET  = 16'd57672;
  localparam logic [FRAC_W:0] FRAC_ONE = 17'h10000;

  localparam choice_t CHOICE_MAX = 3'd5;
  localparam choice_t CHOICE_HALF = 3'd3;

  // Moves are numbered in the order the pair sites are listed.
  typedef enum logic [1:0] {
    MV_UP    = 2'd0,
    MV_DOWN  = 2'd1,
    MV_RIGHT = 2'd2,
    MV_LEFT  = 2'd3
  } move_t;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_BIRTH      = 3'd1,
    EV_LONE_DEATH = 3'd2,
    EV_PAIR_BIRTH = 3'd3,
    EV_PAIR_DEATH = 3'd4,
    EV_KEPT       = 3'd5
  } event_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_PAIR,
    ST_TARGET,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

>>> rtl/tcu_if.sv
// Request and result channel interfaces of the contact update engine.
`default_nettype none

interface tcu_req_if;
  import tcu_pkg::*;

  logic    valid;
  logic    ready;
  action_t action;
  coord_t  row;
  coord_t  col;
  logic    write_value;
  frac_t   draw_main;
  frac_t   draw_second;
  dir_t    direction;
  choice_t pair_choice;

  modport source (
    output valid, action, row, col, write_value, draw_main, draw_second,
           direction, pair_choice,
    input  ready
  );

  modport sink (
    input  valid, action, row, col, write_value, draw_main, draw_second,
           direction, pair_choice,
    output ready
  );
endinterface

interface tcu_res_if;
  import tcu_pkg::*;

  logic   valid;
  logic   ready;
  logic   read_value;
  event_t event_res;
  coord_t target_row;
  coord_t target_col;
  count_t occupied_count;

  modport source (
    output valid, read_value, event_res, target_row, target_col, occupied_count,
    input  ready
  );

  modport sink (
    input  valid, read_value, event_res, target_row, target_col, occupied_count,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/tcu_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none

module tcu_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

>>> rtl/tcu_step.sv
// Shared wrapping step unit that finds the lattice site next to a given site.
`default_nettype none

module tcu_step (
  input  wire tcu_pkg::coord_t base_row,
  input  wire tcu_pkg::coord_t base_col,
  input  wire tcu_pkg::move_t  move,
  output tcu_pkg::coord_t      step_row,
  output tcu_pkg::coord_t      step_col
);
  import tcu_pkg::*;

  localparam coord_t EDGE = coord_t'(SIDE - 1);

  coord_t row_up;
  coord_t row_down;
  coord_t col_left;
  coord_t col_right;

  assign row_up    = (base_row == '0)   ? EDGE : base_row - 1'b1;
  assign row_down  = (base_row == EDGE) ? '0   : base_row + 1'b1;
  assign col_left  = (base_col == '0)   ? EDGE : base_col - 1'b1;
  assign col_right = (base_col == EDGE) ? '0   : base_col + 1'b1;

  always_comb begin
    step_row = base_row;
    step_col = base_col;
    case (move)
      MV_UP:    step_row = row_up;
      MV_DOWN:  step_row = row_down;
      MV_RIGHT: step_col = col_right;
      MV_LEFT:  step_col = col_left;
      default:  step_row = base_row;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/tricritical_contact_update.sv
// Top level of the tricritical contact update engine: sequencer, counters and lattice.
// After reset the lattice is cleared one site a cycle, all 1048576 sites; no request
// is taken meanwhile, and the probabilities return to their reset values at once.
// States per request: LOOK, DONE for reads, writes and empty sites; LOOK, PAIR, DONE
// for lone birth or death, pair death or kept; LOOK, PAIR, TARGET, DONE for pair birth.
// One request at a time, taken in IDLE: each lattice access uses the single memory port.
// A finished result waits in the output register while the next request is taken.
`default_nettype none

module tricritical_contact_update (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [tcu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tcu_pkg::FRAC_W-1:0]        cfg_data,
  tcu_req_if.sink                                req,
  tcu_res_if.source                              res
);
  import tcu_pkg::*;

  function automatic move_t dir_move(input dir_t d);
    move_t m;
    case (d)
      DIR_UP:   m = MV_UP;
      DIR_DOWN: m = MV_DOWN;
      DIR_LEFT: m = MV_LEFT;
      default:  m = MV_RIGHT;
    endcase
    return m;
  endfunction

  function automatic move_t opposite(input move_t m);
    move_t o;
    case (m)
      MV_UP:    o = MV_DOWN;
      MV_DOWN:  o = MV_UP;
      MV_RIGHT: o = MV_LEFT;
      default:  o = MV_RIGHT;
    endcase
    return o;
  endfunction

  state_t  state;
  state_t  state_next;
  addr_t   clr_addr;
  count_t  occupied;
  frac_t   birth_prob;
  frac_t   pair_prob;
  logic    res_valid;

  action_t act;
  coord_t  site_row;
  coord_t  site_col;
  logic    wv;
  frac_t   d1;
  frac_t   d2;
  dir_t    dir;
  choice_t pc;
  logic    in_range;
  logic    rd;
  coord_t  nbr_row;
  coord_t  nbr_col;
  coord_t  tgt_row;
  coord_t  tgt_col;
  event_t  ev;

  logic    out_read;
  event_t  out_event;
  coord_t  out_row;
  coord_t  out_col;
  count_t  out_count;

  logic    ram_we;
  addr_t   ram_addr;
  logic    ram_wdata;
  logic    ram_rdata;

  coord_t  base_row;
  coord_t  base_col;
  move_t   move;
  coord_t  step_row;
  coord_t  step_col;

  logic    cnt_inc;
  logic    cnt_dec;
  logic    out_load;
  event_t  ev_pair;
  coord_t  tgt_row_pair;
  coord_t  tgt_col_pair;

  logic    p_hit;
  logic    q_hit;
  logic    d2_hit;
  choice_t pc_sat;
  logic    far_side;
  logic [1:0] slot;
  move_t   excl;
  move_t   pair_mv;

  assign p_hit  = d1 < birth_prob;
  assign q_hit  = d1 < pair_prob;
  assign d2_hit = {1'b0, d2} < (FRAC_ONE - {1'b0, birth_prob});

  assign pc_sat   = (pc > CHOICE_MAX) ? CHOICE_MAX : pc;
  assign far_side = pc_sat >= CHOICE_HALF;
  assign slot     = far_side ? 2'(pc_sat - CHOICE_HALF) : 2'(pc_sat);
  assign excl     = far_side ? opposite(dir_move(dir)) : dir_move(dir);
  assign pair_mv  = move_t'(slot + 2'((slot >= 2'(excl)) ? 1 : 0));

  tcu_step u_step (
    .base_row (base_row),
    .base_col (base_col),
    .move     (move),
    .step_row (step_row),
    .step_col (step_col)
  );

  tcu_ram #(
    .WIDTH (1),
    .DEPTH (1 << ADDR_W)
  ) u_lattice (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign req.ready = (state == ST_IDLE);

  assign res.valid          = res_valid;
  assign res.read_value     = out_read;
  assign res.event_res      = out_event;
  assign res.target_row     = out_row;
  assign res.target_col     = out_col;
  assign res.occupied_count = out_count;

  always_comb begin
    state_next   = state;
    ram_we       = 1'b0;
    ram_addr     = {site_row, site_col};
    ram_wdata    = 1'b0;
    base_row     = site_row;
    base_col     = site_col;
    move         = dir_move(dir);
    cnt_inc      = 1'b0;
    cnt_dec      = 1'b0;
    out_load     = 1'b0;
    ev_pair      = EV_KEPT;
    tgt_row_pair = '0;
    tgt_col_pair = '0;
    case (state)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_addr;
        if (clr_addr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        ram_addr = {req.row, req.col};
        if (req.valid) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_next = ST_DONE;
        if (in_range && act == ACT_WRITE) begin
          ram_we    = 1'b1;
          ram_wdata = wv;
          cnt_inc   = wv & ~ram_rdata;
          cnt_dec   = ~wv & ram_rdata;
        end else if (in_range && act == ACT_UPDATE && ram_rdata) begin
          ram_addr   = {step_row, step_col};
          state_next = ST_PAIR;
        end
      end
      ST_PAIR: begin
        base_row = far_side ? nbr_row : site_row;
        base_col = far_side ? nbr_col : site_col;
        move     = pair_mv;
        state_next = ST_DONE;
        if (!ram_rdata) begin
          ram_we = 1'b1;
          if (p_hit) begin
            ram_addr     = {nbr_row, nbr_col};
            ram_wdata    = 1'b1;
            cnt_inc      = 1'b1;
            ev_pair      = EV_BIRTH;
            tgt_row_pair = nbr_row;
            tgt_col_pair = nbr_col;
          end else begin
            cnt_dec      = 1'b1;
            ev_pair      = EV_LONE_DEATH;
            tgt_row_pair = site_row;
            tgt_col_pair = site_col;
          end
        end else if (q_hit) begin
          ram_addr     = {step_row, step_col};
          ev_pair      = EV_PAIR_BIRTH;
          tgt_row_pair = step_row;
          tgt_col_pair = step_col;
          state_next   = ST_TARGET;
        end else if (d2_hit) begin
          ram_we       = 1'b1;
          cnt_dec      = 1'b1;
          ev_pair      = EV_PAIR_DEATH;
          tgt_row_pair = site_row;
          tgt_col_pair = site_col;
        end
      end
      ST_TARGET: begin
        ram_we     = 1'b1;
        ram_addr   = {tgt_row, tgt_col};
        ram_wdata  = 1'b1;
        cnt_inc    = ~ram_rdata;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!res_valid || res.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      occupied   <= '0;
      birth_prob <= BIRTH_RESET;
      pair_prob  <= PAIR_RESET;
      res_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cnt_inc) begin
        occupied <= occupied + 1'b1;
      end else if (cnt_dec) begin
        occupied <= occupied - 1'b1;
      end
      if (cfg_we) begin
        if (cfg_index == CFG_BIRTH) begin
          birth_prob <= cfg_data;
        end else if (cfg_index == CFG_PAIR) begin
          pair_prob <= cfg_data;
        end
      end
      if (out_load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req.valid) begin
      act      <= req.action;
      site_row <= req.row;
      site_col <= req.col;
      wv       <= req.write_value;
      d1       <= req.draw_main;
      d2       <= req.draw_second;
      dir      <= req.direction;
      pc       <= req.pair_choice;
      in_range <= (int'(req.row) < SIDE) && (int'(req.col) < SIDE);
    end
    if (state == ST_LOOK) begin
      rd      <= in_range & ram_rdata;
      ev      <= EV_NONE;
      tgt_row <= '0;
      tgt_col <= '0;
      nbr_row <= step_row;
      nbr_col <= step_col;
    end
    if (state == ST_PAIR) begin
      ev      <= ev_pair;
      tgt_row <= tgt_row_pair;
      tgt_col <= tgt_col_pair;
    end
    if (out_load) begin
      out_read  <= rd;
      out_event <= ev;
      out_row   <= tgt_row;
      out_col   <= tgt_col;
      out_count <= occupied;
    end
  end

  a_accept_starts_look: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state == ST_LOOK)
    else $error("accepted request did not start a lattice lookup");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    occupied <= count_t'(CELLS))
    else $error("occupied count exceeds lattice size");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (occupied == $past(occupied) || occupied == $past(occupied) + 1'b1
                     || occupied == $past(occupied) - 1'b1))
    else $error("occupied count moved by more than one");

  a_quiet_targets: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.event_res == EV_NONE || res.event_res == EV_KEPT)
      |-> res.target_row == '0 && res.target_col == '0)
    else $error("event without a write carries a target site");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_CLEAR || state == ST_LOOK || state == ST_PAIR
                || state == ST_TARGET))
    else $error("lattice written outside a write state");

endmodule

`default_nettype wire
